// File: src/keyword_token_lexer_macros.svh
// ----------------------------------------------------------------------------
// Keyword token lexer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_LEXER_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication
`define KLEX_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define KLEX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/klex_pkg.sv
// ----------------------------------------------------------------------------
// Keyword token lexer package
// Byte classes, scan modes, token kinds, keyword table and shared types.
// ----------------------------------------------------------------------------
package klex_pkg;

	// Token kinds
	localparam logic [4:0] K_ILLEGAL = 5'd0;
	localparam logic [4:0] K_EOF     = 5'd1;
	localparam logic [4:0] K_IDENT   = 5'd2;
	localparam logic [4:0] K_INT     = 5'd3;
	localparam logic [4:0] K_ASSIGN  = 5'd4;
	localparam logic [4:0] K_PLUS    = 5'd5;
	localparam logic [4:0] K_MINUS   = 5'd6;
	localparam logic [4:0] K_BANG    = 5'd7;
	localparam logic [4:0] K_STAR    = 5'd8;
	localparam logic [4:0] K_SLASH   = 5'd9;
	localparam logic [4:0] K_LT      = 5'd10;
	localparam logic [4:0] K_GT      = 5'd11;
	localparam logic [4:0] K_EQ      = 5'd12;
	localparam logic [4:0] K_NOTEQ   = 5'd13;
	localparam logic [4:0] K_COMMA   = 5'd14;
	localparam logic [4:0] K_SEMI    = 5'd15;
	localparam logic [4:0] K_LPAREN  = 5'd16;
	localparam logic [4:0] K_RPAREN  = 5'd17;
	localparam logic [4:0] K_LBRACE  = 5'd18;
	localparam logic [4:0] K_RBRACE  = 5'd19;
	localparam logic [4:0] K_KW_BASE = 5'd20;

	// Byte classes, decided in the front end
	localparam logic [2:0] CLS_EOF    = 3'd0;
	localparam logic [2:0] CLS_SPACE  = 3'd1;
	localparam logic [2:0] CLS_EQ     = 3'd2;
	localparam logic [2:0] CLS_BANG   = 3'd3;
	localparam logic [2:0] CLS_LETTER = 3'd4;
	localparam logic [2:0] CLS_DIGIT  = 3'd5;
	localparam logic [2:0] CLS_SINGLE = 3'd6;

	// Scan modes of the back end
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_EQ     = 3'd3;
	localparam logic [2:0] MODE_BANG   = 3'd4;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Queue between front and back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Keywords, packed first character highest, right aligned
	localparam int KW_COUNT = 7;
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'h666E,          // fn
		64'h6C6574,        // let
		64'h6966,          // if
		64'h656C7365,      // else
		64'h74727565,      // true
		64'h66616C7365,    // false
		64'h72657475726E   // return
	};
	localparam logic [15:0] KW_LEN [KW_COUNT] = '{
		16'd2, 16'd3, 16'd2, 16'd4, 16'd4, 16'd5, 16'd6
	};

	// One classified byte
	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] text;
		logic [4:0] kind;
	} klex_item_t;

	// One token
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} klex_token_t;

	// Match a short identifier against the keyword table
	function automatic logic [4:0] kw_lookup(input logic [63:0] window,
						 input logic [15:0] len);
		logic [4:0] kind;
		kind = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (KW_LEN[i] == len && KW_TEXT[i] == window) begin
				kind = K_KW_BASE + 5'(i);
			end
		end
		return kind;
	endfunction

endpackage

// File: src/klex_front.sv
// ----------------------------------------------------------------------------
// Keyword token lexer front end
// Accepts text bytes, classifies them and registers them towards the queue.
// ----------------------------------------------------------------------------
module klex_front import klex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] text_byte,
	output logic       push_valid,
	input  logic       push_ready,
	output klex_item_t push_item
);

	logic       valid_s1;
	klex_item_t item_s1;
	klex_item_t item_d;

	// Classify the incoming byte
	always_comb begin
		item_d.text = text_byte;
		item_d.kind = K_ILLEGAL;
		case (text_byte) inside
			8'h00: item_d.cls = CLS_EOF;
			8'h20, 8'h09, 8'h0A, 8'h0D: item_d.cls = CLS_SPACE;
			8'h3D: item_d.cls = CLS_EQ;
			8'h21: item_d.cls = CLS_BANG;
			[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F: item_d.cls = CLS_LETTER;
			[8'h30:8'h39]: item_d.cls = CLS_DIGIT;
			default: item_d.cls = CLS_SINGLE;
		endcase
		case (text_byte)
			8'h2B: item_d.kind = K_PLUS;
			8'h2D: item_d.kind = K_MINUS;
			8'h2A: item_d.kind = K_STAR;
			8'h2F: item_d.kind = K_SLASH;
			8'h3C: item_d.kind = K_LT;
			8'h3E: item_d.kind = K_GT;
			8'h2C: item_d.kind = K_COMMA;
			8'h3B: item_d.kind = K_SEMI;
			8'h28: item_d.kind = K_LPAREN;
			8'h29: item_d.kind = K_RPAREN;
			8'h7B: item_d.kind = K_LBRACE;
			8'h7D: item_d.kind = K_RBRACE;
			default: item_d.kind = K_ILLEGAL;
		endcase
	end

	// Take a byte whenever the stage is empty or drains this cycle
	assign text_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// File: src/klex_queue.sv
// ----------------------------------------------------------------------------
// Keyword token lexer queue
// Short first-in first-out buffer of classified bytes between the two ends.
// ----------------------------------------------------------------------------
module klex_queue import klex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  klex_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output klex_item_t pop_item
);

	klex_item_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: src/klex_back.sv
// ----------------------------------------------------------------------------
// Keyword token lexer back end
// Scans classified bytes, keeps the pending token and issues tokens.
// ----------------------------------------------------------------------------
module klex_back import klex_pkg::*; #(
	parameter int POSITION_BITS     = 16,
	parameter int KEYWORD_MAX_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  klex_item_t  pop_item,
	output logic        token_valid,
	input  logic        token_ready,
	output klex_token_t token
);

	localparam int WIN_BITS = 8 * KEYWORD_MAX_CHARS;

	logic [2:0]               mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [15:0]              pstart_q;
	logic [15:0]              plen_q;
	logic [WIN_BITS-1:0]      kwin_q;
	logic                     phase_q;
	logic                     out_valid_q;
	klex_token_t              out_q;

	logic        is_ext;
	logic        is_pair;
	logic        has_flush;
	logic        has_tail;
	logic        two;
	logic        need_emit;
	logic        can_out;
	logic        step;
	logic        pop;
	logic        load;
	logic [31:0] pos_ext;
	logic [4:0]  ident_kind;
	klex_token_t first_tok;
	klex_token_t tail_tok;
	klex_token_t emit_tok;

	assign pos_ext = 32'(pos_q);

	// Decide what this byte does to the pending token
	always_comb begin
		is_ext = (mode_q == MODE_IDENT && pop_item.cls == CLS_LETTER)
			|| (mode_q == MODE_NUMBER && pop_item.cls == CLS_DIGIT);
		is_pair = (mode_q == MODE_EQ || mode_q == MODE_BANG) && pop_item.cls == CLS_EQ;
		has_flush = !is_ext && !is_pair && mode_q != MODE_IDLE;
		has_tail = !is_ext && !is_pair
			&& (pop_item.cls == CLS_EOF || pop_item.cls == CLS_SINGLE);
		two = has_flush && has_tail;
		need_emit = is_pair || has_flush || has_tail;
	end

	// Identifier kind from the keyword window
	always_comb begin
		if (plen_q > 16'(KEYWORD_MAX_CHARS)) begin
			ident_kind = K_IDENT;
		end else begin
			ident_kind = kw_lookup(64'(kwin_q), plen_q);
		end
	end

	// Build the candidate tokens
	always_comb begin
		tail_tok.start = pos_ext[15:0];
		tail_tok.last  = 1'b1;
		if (pop_item.cls == CLS_EOF) begin
			tail_tok.kind   = K_EOF;
			tail_tok.length = 16'd0;
		end else begin
			tail_tok.kind   = pop_item.kind;
			tail_tok.length = (pop_item.kind == K_ILLEGAL) ? 16'd0 : 16'd1;
		end

		first_tok = tail_tok;
		if (is_pair) begin
			first_tok.kind   = (mode_q == MODE_EQ) ? K_EQ : K_NOTEQ;
			first_tok.start  = pstart_q;
			first_tok.length = 16'd2;
			first_tok.last   = 1'b1;
		end else if (has_flush) begin
			first_tok.start = pstart_q;
			first_tok.last  = !has_tail;
			case (mode_q)
				MODE_IDENT: begin
					first_tok.kind   = ident_kind;
					first_tok.length = plen_q;
				end
				MODE_NUMBER: begin
					first_tok.kind   = K_INT;
					first_tok.length = plen_q;
				end
				MODE_EQ: begin
					first_tok.kind   = K_ASSIGN;
					first_tok.length = 16'd1;
				end
				default: begin
					first_tok.kind   = K_BANG;
					first_tok.length = 16'd1;
				end
			endcase
		end

		emit_tok = phase_q ? tail_tok : first_tok;
	end

	// Step when the output slot can take what this byte gives
	assign can_out   = !out_valid_q || token_ready;
	assign step      = pop_valid && (!need_emit || can_out);
	assign pop       = step && !(two && !phase_q);
	assign load      = step && need_emit;
	assign pop_ready = pop;

	// Scan state, updated once the byte is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			kwin_q   <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= 1'b0;
			end else if (step) begin
				phase_q <= 1'b1;
			end
			if (pop) begin
				pos_q <= pos_q + 1'b1;
				if (is_ext) begin
					if (plen_q < 16'(KEYWORD_MAX_CHARS)) begin
						kwin_q <= {kwin_q[WIN_BITS-9:0], pop_item.text};
					end
					if (plen_q != LEN_MAX) begin
						plen_q <= plen_q + 1'b1;
					end
				end else begin
					pstart_q <= '0;
					plen_q   <= '0;
					kwin_q   <= '0;
					mode_q   <= MODE_IDLE;
					if (!is_pair) begin
						case (pop_item.cls)
							CLS_EOF: pos_q <= '0;
							CLS_EQ: mode_q <= MODE_EQ;
							CLS_BANG: mode_q <= MODE_BANG;
							CLS_LETTER: mode_q <= MODE_IDENT;
							CLS_DIGIT: mode_q <= MODE_NUMBER;
							default: mode_q <= MODE_IDLE;
						endcase
						if (pop_item.cls == CLS_EQ || pop_item.cls == CLS_BANG
							|| pop_item.cls == CLS_LETTER || pop_item.cls == CLS_DIGIT) begin
							pstart_q <= pos_ext[15:0];
							plen_q   <= 16'd1;
							kwin_q   <= WIN_BITS'(pop_item.text);
						end
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_out) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= emit_tok;
		end
	end

	assign token_valid = out_valid_q;
	assign token       = out_q;

endmodule

// File: src/keyword_token_lexer.sv
// ----------------------------------------------------------------------------
// Keyword token lexer
// Streaming lexer: text bytes in, tokens with kind, start and length out.
// ----------------------------------------------------------------------------
// The lexer takes one text byte per cycle and gives tokens one per cycle
// while neither side stalls. A byte that ends a pending token and is itself
// an operator, an unknown byte or the end of text gives two tokens and holds
// the scanner while they leave in turn through its single output register.
// A byte passes a classifying register and a four-entry queue before the
// scanner, whose output register then presents its tokens; the queue lets
// input keep flowing while the token side stalls briefly. Identifiers and
// integers are held until the byte that ends them, and '=' or '!' until the
// next byte. The byte 0 flushes any pending token, gives an end token and
// restarts offsets at zero.
`include "keyword_token_lexer_macros.svh"

module keyword_token_lexer import klex_pkg::*; #(
	parameter int POSITION_BITS     = 16,
	parameter int KEYWORD_MAX_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [4:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic        push_valid;
	logic        push_ready;
	klex_item_t  push_item;
	logic        pop_valid;
	logic        pop_ready;
	klex_item_t  pop_item;
	klex_token_t token;

	// Classify incoming bytes
	klex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Buffer classified bytes
	klex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Scan and issue tokens
	klex_back #(
		.POSITION_BITS     (POSITION_BITS),
		.KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token)
	);

	assign token_kind   = token.kind;
	assign token_start  = token.start;
	assign token_length = token.length;
	assign last_of_run  = token.last;

	// An end token closes the run and has no length
	`KLEX_ASSERT_IMPLIES(a_eof_shape, clk, arst_n, token_valid && token_kind == K_EOF, token_length == 16'd0 && last_of_run, "end token malformed")

	// Two-character operators always span two bytes and end the run
	`KLEX_ASSERT_IMPLIES(a_pair_shape, clk, arst_n, token_valid && (token_kind == K_EQ || token_kind == K_NOTEQ), token_length == 16'd2 && last_of_run, "paired operator malformed")

	// A token that is not the last of its byte is always followed by another
	`KLEX_ASSERT_NEXT(a_run_closes, clk, arst_n, token_valid && token_ready && !last_of_run, token_valid, "token run left open")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Keyword token lexer testbench
// Sends text bytes through the lexer and compares every token that comes out
// with a token stream predicted byte by byte inside the bench. Both sides idle
// and stall at random. Directed text covers operator pairs, flushes and
// illegal bytes. A long run covers names past the keyword window and long
// numbers. Random programs of keywords, names, numbers and operators, mixed
// with raw noise bytes, make up the bulk of the stimulus.
// ----------------------------------------------------------------------------
module tb_top;
	import klex_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] END_BYTE = 8'h00;

	// Keyword kinds, in table order
	localparam logic [4:0] K_FN     = K_KW_BASE + 5'd0;
	localparam logic [4:0] K_LET    = K_KW_BASE + 5'd1;
	localparam logic [4:0] K_IF     = K_KW_BASE + 5'd2;
	localparam logic [4:0] K_ELSE   = K_KW_BASE + 5'd3;
	localparam logic [4:0] K_TRUE   = K_KW_BASE + 5'd4;
	localparam logic [4:0] K_FALSE  = K_KW_BASE + 5'd5;
	localparam logic [4:0] K_RETURN = K_KW_BASE + 5'd6;

	localparam string OPERATORS = "+-*/<>,;(){}";
	string keyword_words[7] = '{"fn", "let", "if", "else", "true", "false", "return"};

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_ready;
	logic [7:0]  text_byte;
	logic        token_valid;
	logic        token_ready;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	// Lexer state as predicted
	logic [2:0]  lex_mode;
	logic [15:0] lex_offset;
	logic [15:0] run_start;
	logic [15:0] run_len;
	logic [47:0] run_text;

	klex_token_t tokens_due[$];
	klex_token_t step_tokens[$];

	int  errors;
	int  bytes_sent;
	int  quiet_cycles;
	bit  src_idle;
	bit  snk_idle;

	keyword_token_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Token prediction
	// ------------------------------------------------------------------
	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	// Only short names can be keywords; the text window is exact for them
	function automatic logic [4:0] word_kind();
		if (run_len > 16'd6)
			return K_IDENT;
		case (run_text)
		"fn":     return K_FN;
		"let":    return K_LET;
		"if":     return K_IF;
		"else":   return K_ELSE;
		"true":   return K_TRUE;
		"false":  return K_FALSE;
		"return": return K_RETURN;
		default:  return K_IDENT;
		endcase
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] b);
		case (b)
		"+":     return K_PLUS;
		"-":     return K_MINUS;
		"*":     return K_STAR;
		"/":     return K_SLASH;
		"<":     return K_LT;
		">":     return K_GT;
		",":     return K_COMMA;
		";":     return K_SEMI;
		"(":     return K_LPAREN;
		")":     return K_RPAREN;
		"{":     return K_LBRACE;
		"}":     return K_RBRACE;
		default: return K_ILLEGAL;
		endcase
	endfunction

	task automatic emit(input logic [4:0] kind, input logic [15:0] start,
			    input logic [15:0] len);
		step_tokens.push_back('{kind: kind, start: start, length: len, last: 1'b0});
	endtask

	task automatic clear_run();
		lex_mode = MODE_IDLE;
		run_start = '0;
		run_len = '0;
		run_text = '0;
	endtask

	task automatic open_run(input logic [7:0] b, input logic [2:0] mode);
		lex_mode = mode;
		run_start = lex_offset;
		run_len = 16'd1;
		run_text = {40'd0, b};
	endtask

	task automatic grow_run(input logic [7:0] b);
		if (run_len < 16'd6)
			run_text = {run_text[39:0], b};
		if (run_len != LEN_MAX)
			run_len++;
	endtask

	// Work out the tokens that one accepted byte gives
	task automatic lex_byte(input logic [7:0] b);
		logic [4:0] k;
		step_tokens.delete();
		if (lex_mode == MODE_IDENT && is_letter(b)) begin
			grow_run(b);
			lex_offset++;
		end else if (lex_mode == MODE_NUMBER && is_digit(b)) begin
			grow_run(b);
			lex_offset++;
		end else if ((lex_mode == MODE_EQ || lex_mode == MODE_BANG) && b == "=") begin
			emit(lex_mode == MODE_EQ ? K_EQ : K_NOTEQ, run_start, 16'd2);
			clear_run();
			lex_offset++;
		end else begin
			// Flush whatever is pending first
			case (lex_mode)
			MODE_IDENT:  emit(word_kind(), run_start, run_len);
			MODE_NUMBER: emit(K_INT, run_start, run_len);
			MODE_EQ:     emit(K_ASSIGN, run_start, 16'd1);
			MODE_BANG:   emit(K_BANG, run_start, 16'd1);
			default:     ;
			endcase
			clear_run();
			if (b == END_BYTE) begin
				emit(K_EOF, lex_offset, 16'd0);
				lex_offset = '0;
			end else begin
				if (is_space(b))
					;
				else if (b == "=")
					open_run(b, MODE_EQ);
				else if (b == "!")
					open_run(b, MODE_BANG);
				else if (is_letter(b))
					open_run(b, MODE_IDENT);
				else if (is_digit(b))
					open_run(b, MODE_NUMBER);
				else begin
					k = punct_kind(b);
					emit(k, lex_offset, k == K_ILLEGAL ? 16'd0 : 16'd1);
				end
				lex_offset++;
			end
		end
		if (step_tokens.size() != 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH: %s", what);
	endtask

	// Present one byte and hold it until the transfer, then predict
	task automatic send_byte(input logic [7:0] b);
		while (src_idle && $urandom_range(99) < 38) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		lex_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] random_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] space_byte();
		case ($urandom_range(3))
		0:       return 8'h20;
		1:       return 8'h09;
		2:       return 8'h0A;
		default: return 8'h0D;
		endcase
	endfunction

	// One random lexeme, white byte or random nonzero byte
	task automatic send_word();
		case ($urandom_range(9))
		0, 1: send_text(keyword_words[$urandom_range(6)]);
		2, 3: repeat ($urandom_range(8, 1)) send_byte(random_letter());
		4:    repeat ($urandom_range(6, 1)) send_byte(8'("0" + $urandom_range(9)));
		5:    send_byte(OPERATORS[$urandom_range(11)]);
		6: begin
			send_byte($urandom_range(1) ? "=" : "!");
			if ($urandom_range(1))
				send_byte("=");
		end
		7:    send_byte(space_byte());
		default: send_byte(8'($urandom_range(255, 1)));
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Digit ending a name, pairs and held operators, illegal and white bytes
	task automatic test_pairs_and_flush();
		send_text("a1=!=(==,");
		send_byte(8'h80);
		send_byte(8'h20);
		send_byte(8'h09);
		send_byte(8'h0D);
		send_byte(8'h0A);
		send_text("returnx");
		send_byte(8'hFF);
		send_byte(END_BYTE);
	endtask

	// End of text flushing each kind of pending token
	task automatic test_end_flush();
		send_text("!");
		send_byte(END_BYTE);
		send_text("=");
		send_byte(END_BYTE);
		send_text("else");
		send_byte(END_BYTE);
		send_text("70");
		send_byte(END_BYTE);
		send_byte(END_BYTE);
	endtask

	// Long name starting with a keyword, then a long number, with no source idling
	task automatic test_long_run();
		src_idle = 1'b0;
		send_text("return");
		repeat (120) send_byte(random_letter());
		repeat (70) send_byte(8'("0" + $urandom_range(9)));
		send_text(";x");
		send_byte(END_BYTE);
		src_idle = 1'b1;
	endtask

	// Random programs with bursts of noise; one stretch runs with no idling
	task automatic test_random_text();
		int base;
		base = bytes_sent;
		while (bytes_sent - base < 1200) begin
			src_idle = !(bytes_sent - base >= 500 && bytes_sent - base < 800);
			snk_idle = src_idle;
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(20, 1)) begin
					send_word();
					if ($urandom_range(1))
						send_byte(space_byte());
				end
				if ($urandom_range(4) != 0)
					send_byte(END_BYTE);
			end
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Token checking and backpressure
	// ------------------------------------------------------------------
	task automatic check_token();
		klex_token_t want;
		if (tokens_due.size() == 0) begin
			report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
				token_kind, token_start, token_length));
		end else begin
			want = tokens_due.pop_front();
			if (token_kind !== want.kind)
				report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
					token_kind, want.kind, want.start));
			if (token_start !== want.start)
				report_mismatch($sformatf("start %0d, want %0d", token_start, want.start));
			if (token_length !== want.length)
				report_mismatch($sformatf("length %0d, want %0d (start %0d)",
					token_length, want.length, want.start));
			if (last_of_run !== want.last)
				report_mismatch($sformatf("last_of_run %0b, want %0b (start %0d)",
					last_of_run, want.last, want.start));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (token_valid && token_ready)
				check_token();
			token_ready <= !(snk_idle && $urandom_range(99) < 38);
		end
	end

	// Count cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && text_ready) || (token_valid && token_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = '0;
		token_ready = 1'b0;
		errors = 0;
		bytes_sent = 0;
		quiet_cycles = 0;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		lex_offset = '0;
		clear_run();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pairs_and_flush();
		test_end_flush();
		test_long_run();
		test_random_text();

		// Drop valid and drain the remaining tokens
		text_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
